// ----- design/cdss_pkg.sv -----
package cdss_pkg;

	// register map, index = paddr[3:2]
	localparam int unsigned RegCount = 3;
	localparam logic [1:0] REG_SMOOTH_TIME = 2'd0;
	localparam logic [1:0] REG_STEP_TIME   = 2'd1;
	localparam logic [1:0] REG_SPEED_LIMIT = 2'd2;

	localparam logic [31:0] SMOOTH_TIME_RST = 32'd19661;
	localparam logic [16:0] STEP_TIME_RST   = 17'd1092;
	localparam logic [30:0] SPEED_LIMIT_RST = 31'h7FFF_FFFF;

	// Q16.16 constants
	localparam logic [16:0] ONE_Q = 17'd65536;
	localparam logic [14:0] K048  = 15'd31457;
	localparam logic [13:0] K0235 = 14'd15401;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// divider width and iteration count
	localparam int unsigned DivW = 34;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quotient;
	} div_res_t;

	// floor(a*b/2^16) saturated to signed 32 bits
	function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		logic signed [49:0] s;
		p = a * b;
		s = p[65:16];
		if (s > 50'sd2147483647)
			return SAT_MAX;
		else if (s < -50'sd2147483648)
			return SAT_MIN;
		else
			return s[31:0];
	endfunction

	// saturate a 33-bit signed value to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v > 33'sd2147483647)
			return SAT_MAX;
		else if (v < -33'sd2147483648)
			return SAT_MIN;
		else
			return v[31:0];
	endfunction

endpackage

// ----- design/cdss_in_if.sv -----
interface cdss_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] current_value;
	logic signed [31:0] target_value;

	modport source (output valid, current_value, target_value, input ready);
	modport sink (input valid, current_value, target_value, output ready);
endinterface

// ----- design/cdss_out_if.sv -----
interface cdss_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] smoothed_value;
	logic signed [31:0] new_velocity;

	modport source (output valid, smoothed_value, new_velocity, input ready);
	modport sink (input valid, smoothed_value, new_velocity, output ready);
endinterface

// ----- design/critically_damped_smoothing_step_core.sv -----
// channel   dir  handshake      payload
// in_ch     in   valid/ready    current_value, target_value (signed Q16.16)
// out_ch    out  valid/ready    smoothed_value, new_velocity (signed Q16.16)
// apb       in   psel/penable   smooth_time, step_time, speed_limit
//
// an item passes through two runs of the shared restoring divider (34
// quotient bits, then a done strobe; omega, then the decay factor), the
// sequencer steps on the one shared Q16.16 multiplier and the idle state
// before the next ready.
// in_ch.ready is high only while the sequencer is idle.
// a finished result waits in the output register; a stalled out_ch holds
// the sequencer in its last step. reset clears velocity and loads the register defaults.
module critically_damped_smoothing_step_core
	import cdss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cdss_in_if.sink     in_ch,
	cdss_out_if.source  out_ch
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV1 = 4'd1;
	localparam logic [3:0] S_X    = 4'd2;
	localparam logic [3:0] S_X2   = 4'd3;
	localparam logic [3:0] S_X3   = 4'd4;
	localparam logic [3:0] S_T1   = 4'd5;
	localparam logic [3:0] S_T2   = 4'd6;
	localparam logic [3:0] S_DEN  = 4'd7;
	localparam logic [3:0] S_MC   = 4'd8;
	localparam logic [3:0] S_DIV2 = 4'd9;
	localparam logic [3:0] S_CHG  = 4'd10;
	localparam logic [3:0] S_M1   = 4'd11;
	localparam logic [3:0] S_TMP  = 4'd12;
	localparam logic [3:0] S_M2   = 4'd13;
	localparam logic [3:0] S_V    = 4'd14;
	localparam logic [3:0] S_R    = 4'd15;

	logic [31:0] smooth_time_q;
	logic [16:0] step_time_q;
	logic [30:0] speed_limit_q;

	logic [3:0]         state_q;
	logic               out_valid_q;
	logic               out_pend_q;
	logic signed [31:0] res_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] out_vel_q;

	logic signed [31:0] from_q, to_q;
	logic [30:0]        omega_q;
	logic [30:0]        x_q, x2_q, x3_q;
	logic [33:0]        den_q;
	logic [16:0]        decay_q;
	logic [30:0]        maxc_q;
	logic signed [31:0] change_q, goal_q, temp_q;
	logic signed [31:0] mres_q;

	logic               div_start;
	logic [DivW-1:0]    div_dividend;
	logic [31:0]        div_divisor;
	div_res_t           div_res;

	logic signed [32:0] mul_a, mul_b;
	logic signed [32:0] diff;
	logic signed [32:0] maxc_s, maxc_n;
	logic               mul_en;
	logic               wr_en;
	logic               out_free;

	// config writes and reads
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_time_q <= SMOOTH_TIME_RST;
			step_time_q   <= STEP_TIME_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SMOOTH_TIME: smooth_time_q <= pwdata;
				REG_STEP_TIME:   step_time_q   <= pwdata[16:0];
				REG_SPEED_LIMIT: speed_limit_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SMOOTH_TIME: prdata = smooth_time_q;
			REG_STEP_TIME:   prdata = {15'd0, step_time_q};
			REG_SPEED_LIMIT: prdata = {1'b0, speed_limit_q};
			default:         prdata = '0;
		endcase
	end

	// shared divider
	cdss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DivW'(35'h2_0000_0000);
		div_divisor  = (smooth_time_q == '0) ? 32'd1 : smooth_time_q;
		if (state_q == S_IDLE) begin
			div_start = in_ch.valid;
		end else if (state_q == S_MC) begin
			div_start    = 1'b1;
			div_dividend = DivW'(35'h1_0000_0000);
			div_divisor  = (den_q > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : den_q[31:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_X: begin
				mul_a = {2'b0, omega_q};
				mul_b = {16'b0, step_time_q};
			end
			S_X2: begin
				mul_a = {mres_q[31], mres_q};
				mul_b = {mres_q[31], mres_q};
			end
			S_X3: begin
				mul_a = {mres_q[31], mres_q};
				mul_b = {2'b0, x_q};
			end
			S_T1: begin
				mul_a = {18'b0, K048};
				mul_b = {2'b0, x2_q};
			end
			S_T2: begin
				mul_a = {19'b0, K0235};
				mul_b = {2'b0, x3_q};
			end
			S_MC: begin
				mul_a = {2'b0, speed_limit_q};
				mul_b = {1'b0, smooth_time_q};
			end
			S_M1: begin
				mul_a = {2'b0, omega_q};
				mul_b = {change_q[31], change_q};
			end
			S_TMP: begin
				mul_a = {1'b0, sat33(33'(vel_q) + 33'(mres_q))};
				mul_a = {mul_a[31], mul_a[31:0]};
				mul_b = {16'b0, step_time_q};
			end
			S_M2: begin
				mul_a = {2'b0, omega_q};
				mul_b = {mres_q[31], mres_q};
			end
			S_V: begin
				mul_a = {1'b0, sat33(33'(vel_q) - 33'(mres_q))};
				mul_a = {mul_a[31], mul_a[31:0]};
				mul_b = {16'b0, decay_q};
			end
			S_R: begin
				mul_a = {1'b0, sat33(33'(change_q) + 33'(temp_q))};
				mul_a = {mul_a[31], mul_a[31:0]};
				mul_b = {16'b0, decay_q};
			end
			default: ;
		endcase
	end

	assign diff     = 33'(from_q) - 33'(to_q);
	assign maxc_s   = {2'b0, maxc_q};
	assign maxc_n   = -maxc_s;
	assign out_free = !out_valid_q || out_ch.ready;

	// multiplier result is held while waiting on the divider or the output
	assign mul_en = (state_q != S_IDLE) && (state_q != S_DIV1) && (state_q != S_DIV2)
		&& (state_q != S_CHG) && !(state_q == S_R && out_pend_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vel_q       <= '0;
			out_valid_q <= 1'b0;
			out_pend_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid)
						state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_res.done)
						state_q <= S_X;
				end
				S_X:    state_q <= S_X2;
				S_X2:   state_q <= S_X3;
				S_X3:   state_q <= S_T1;
				S_T1:   state_q <= S_T2;
				S_T2:   state_q <= S_DEN;
				S_DEN:  state_q <= S_MC;
				S_MC:   state_q <= S_DIV2;
				S_DIV2: begin
					if (div_res.done)
						state_q <= S_CHG;
				end
				S_CHG:  state_q <= S_M1;
				S_M1:   state_q <= S_TMP;
				S_TMP:  state_q <= S_M2;
				S_M2:   state_q <= S_V;
				S_V:    state_q <= S_R;
				S_R: begin
					// last step: vel_q is updated, then the result waits for the output register
					if (!out_pend_q) begin
						vel_q      <= mres_q;
						out_pend_q <= 1'b1;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_pend_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				from_q <= in_ch.current_value;
				to_q   <= in_ch.target_value;
			end
			S_DIV1: begin
				omega_q <= (div_res.quotient > DivW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF
					: div_res.quotient[30:0];
			end
			S_X2: begin
				x_q   <= mres_q[30:0];
				den_q <= 34'(ONE_Q) + 34'(mres_q[30:0]);
			end
			S_X3: x2_q <= mres_q[30:0];
			S_T1: x3_q <= mres_q[30:0];
			S_T2: den_q <= den_q + 34'(mres_q[30:0]);
			S_DEN: den_q <= den_q + 34'(mres_q[30:0]);
			S_DIV2: begin
				maxc_q <= mres_q[30:0];
				if (div_res.done)
					decay_q <= div_res.quotient[16:0];
			end
			S_CHG: begin
				if (diff > maxc_s)
					change_q <= maxc_s[31:0];
				else if (diff < maxc_n)
					change_q <= maxc_n[31:0];
				else
					change_q <= diff[31:0];
			end
			S_M1: goal_q <= sat33(33'(from_q) - 33'(change_q));
			S_M2: temp_q <= mres_q;
			S_R: begin
				if (out_pend_q && out_free) begin
					res_q     <= sat33(33'(goal_q) + 33'(mres_q));
					out_vel_q <= vel_q;
				end
			end
			default: ;
		endcase
		if (mul_en)
			mres_q <= mulq(mul_a, mul_b);
	end

	assign in_ch.ready           = (state_q == S_IDLE);
	assign out_ch.valid          = out_valid_q;
	assign out_ch.smoothed_value = res_q;
	assign out_ch.new_velocity   = out_vel_q;

	// divider results only arrive while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider done outside a wait state");

	// decay factor stays within 0..1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHG |-> decay_q <= ONE_Q)
		else $error("decay factor above one");

	// an accepted item starts the first division
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == S_DIV1))
		else $error("transfer did not start the sequencer");

	// a result is only presented once the sequencer has finished
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (state_q == S_IDLE && $past(state_q) == S_R))
		else $error("result raised outside the last step");

endmodule

// ----- design/cdss_div.sv -----
module cdss_div
	import cdss_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [31:0]     divisor,
	output div_res_t        res
);

	localparam int unsigned CntW = $clog2(DivW + 1);

	logic [31:0]     rem_q;
	logic [DivW-1:0] quo_q;
	logic [31:0]     dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [32:0] shifted;
	logic        ge;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[DivW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			quo_q <= {quo_q[DivW-2:0], ge};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

// ----- bench/cdss_smooth_checker.sv -----
`timescale 1ns / 100ps

module cdss_smooth_checker
	import cdss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] in_current,
	input  logic [31:0] in_target,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_smoothed,
	input  logic [31:0] out_velocity,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic signed [31:0] smoothed;
		logic signed [31:0] velocity;
	} step_result_t;

	step_result_t expected_steps[$];
	logic [31:0] smooth_t;
	logic [16:0] step_t;
	logic [30:0] speed_lim;
	longint kept_vel;

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clipu(input longint unsigned v);
		return (v > 64'd2147483647) ? 64'sd2147483647 : longint'(v);
	endfunction

	// floor(a*b/2^16), saturated; operands fit in 33 bits
	function automatic longint qmul(input longint a, input longint b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return clip32(longint'(p >>> 16));
	endfunction

	// one smoothing step, updates the kept velocity
	function automatic step_result_t smooth_step(input logic signed [31:0] cur,
		input logic signed [31:0] tgt);
		longint unsigned st, om, x, x2, x3, den;
		longint decay, maxc, change, goal, temp, res;
		step_result_t r;
		st = (smooth_t == 0) ? 1 : smooth_t;
		om = clipu((64'd1 << 33) / st);
		x = clipu((om * step_t) >> 16);
		x2 = clipu((x * x) >> 16);
		x3 = clipu((x2 * x) >> 16);
		den = clipu(64'd65536 + x + ((64'd31457 * x2) >> 16) + ((64'd15401 * x3) >> 16));
		decay = longint'((64'd1 << 32) / den);
		maxc = clipu((64'(speed_lim) * smooth_t) >> 16);
		change = longint'(cur) - longint'(tgt);
		if (change > maxc) change = maxc;
		if (change < -maxc) change = -maxc;
		goal = clip32(longint'(cur) - change);
		temp = qmul(clip32(kept_vel + qmul(longint'(om), change)), longint'(step_t));
		kept_vel = qmul(clip32(kept_vel - qmul(longint'(om), temp)), decay);
		res = clip32(goal + qmul(clip32(change + temp), decay));
		r.smoothed = res[31:0];
		r.velocity = kept_vel[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending_count = expected_steps.size();

	// track registers, predict on input transfers, compare output transfers
	always @(posedge clk or negedge arst_n) begin
		step_result_t e;
		if (!arst_n) begin
			smooth_t = SMOOTH_TIME_RST;
			step_t = STEP_TIME_RST;
			speed_lim = SPEED_LIMIT_RST;
			kept_vel = 0;
			expected_steps.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SMOOTH_TIME: smooth_t = pwdata;
					REG_STEP_TIME:   step_t = pwdata[16:0];
					REG_SPEED_LIMIT: speed_lim = pwdata[30:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_steps.size() == 0) begin
					report_mismatch("unexpected result", out_smoothed, 32'h0);
				end else begin
					e = expected_steps.pop_front();
					if (out_smoothed !== e.smoothed)
						report_mismatch("smoothed_value", out_smoothed, e.smoothed);
					if (out_velocity !== e.velocity)
						report_mismatch("new_velocity", out_velocity, e.velocity);
				end
			end
			if (in_valid && in_ready)
				expected_steps.push_back(smooth_step(in_current, in_target));
		end
	end

endmodule

// ----- bench/tb_critically_damped_smoothing_step_core.sv -----
`timescale 1ns / 100ps

module tb_critically_damped_smoothing_step_core;
	import cdss_pkg::*;

	localparam int IdleLimit = 20000;
	localparam int RandomSteps = 900;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending_count;
	int idle_cycles = 0;
	bit hold_sink = 0;
	bit stim_done = 0;

	cdss_in_if in_ch();
	cdss_out_if out_ch();

	critically_damped_smoothing_step_core uut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	cdss_smooth_checker chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_current(in_ch.current_value), .in_target(in_ch.target_value),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_smoothed(out_ch.smoothed_value), .out_velocity(out_ch.new_velocity),
		.fail_count, .pending_count
	);

	// clock
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.current_value = 0;
		in_ch.target_value = 0;
		out_ch.ready = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(20, 200);
		return $urandom_range(1, 4);
	endfunction

	// receiver with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (!arst_n || hold_sink)
			out_ch.ready <= 0;
		else
			out_ch.ready <= ($urandom_range(0, 3) != 0) || (gap_len() == 0);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb_critically_damped_smoothing_step_core NOT OK");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_step(input logic [31:0] cur, input logic [31:0] tgt);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.current_value <= cur;
		in_ch.target_value <= tgt;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		@(posedge clk);
		in_ch.valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom_range(0, 200000) - 100000;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	logic [31:0] smooth_set[6] = '{32'd19661, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd3000};
	logic [31:0] step_set[6] = '{32'd1092, 32'd0, 32'd65536, 32'h1FFFF, 32'd4000, 32'd655};
	logic [31:0] speed_set[6] = '{32'h7FFF_FFFF, 32'd0, 32'd65536, 32'h7FFF_FFFF, 32'd1000,
		32'hFFFF_FFFF};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes at reset settings
		send_step(32'h0, 32'h0);
		send_step(32'h7FFF_FFFF, 32'h8000_0000);
		send_step(32'h8000_0000, 32'h7FFF_FFFF);
		send_step(32'h0001_0000, 32'h0);
		send_step(32'h8000_0000, 32'h8000_0000);
		send_step(32'hFFFF_FFFF, 32'h0000_0001);
		drain();

		// zero smooth time, zero speed limit, long step
		reg_write(REG_SMOOTH_TIME, 32'd0);
		reg_write(REG_SPEED_LIMIT, 32'd0);
		reg_write(REG_STEP_TIME, 32'h1FFFF);
		reg_write(2'd3, 32'h1234);
		send_step(32'h0005_0000, 32'h0);
		send_step(32'h7FFF_FFFF, 32'h8000_0000);
		send_step(32'h8000_0000, 32'h0);
		drain();

		// random phases across settings
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_SMOOTH_TIME, smooth_set[ph]);
			reg_write(REG_STEP_TIME, step_set[ph]);
			reg_write(REG_SPEED_LIMIT, ph == 4 ? $urandom : speed_set[ph]);
			if (ph == 2) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_sink = 1;
						repeat (600) @(posedge clk);
						hold_sink = 0;
					end
				join_none
			end
			for (int i = 0; i < RandomSteps / 6; i++)
				send_step(rand_val(), rand_val());
			drain();
		end

		stim_done = 1;
		if (fail_count == 0)
			$display("tb_critically_damped_smoothing_step_core OK");
		else
			$display("tb_critically_damped_smoothing_step_core NOT OK");
		$finish;
	end

endmodule
